// ===== design/zba_pkg.sv =====
// Package for the zone bitmap allocator: field widths, command and status codes,
// parameter defaults and the find-first-zero helper. No dependencies.
package zba_pkg;

    localparam int CMD_W = 1;
    localparam int BLK_W = 17;
    localparam int ST_W  = 3;
    localparam int MB_W  = 3;
    localparam int FDZ_W = 16;

    localparam int MAP_BLOCKS_DEF         = 8;
    localparam int BITS_PER_MAP_BLOCK_DEF = 8192;
    localparam int WORD_WIDTH_DEF         = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_ALLOC = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
    localparam logic [ST_W-1:0] ST_FREED = 3'd2;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE = 3'd4;

    // Index of the lowest clear bit; caller fills unused upper bits with ones.
    function automatic logic [6:0] ffz64(input logic [63:0] w);
        logic [6:0] idx;
        idx = 7'd64;
        for (int b = 63; b >= 0; b--) begin
            if (!w[b]) begin
                idx = 7'(b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/zba_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// Used for the usage bitmap and for its full-word summary. No dependencies.
module zba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/zone_bitmap_allocator.sv =====
// Zone bitmap allocator top level. Depends on zba_pkg and zba_ram.
// Allocate: scan summary words for one with a free bit, read that bitmap word, set its
// lowest clear bit, write back; a full map ends the scan. Free: reciprocal-multiply index
// steps, both reads, clear and write-back; out of range goes straight to the result. A new
// command is taken only once the last result is in the output register, which holds it
// until taken. Active-low sync reset clears WORD_COUNT (2048) words with o_in_ready low.
module zone_bitmap_allocator #(
    parameter int MAP_BLOCKS         = zba_pkg::MAP_BLOCKS_DEF,
    parameter int BITS_PER_MAP_BLOCK = zba_pkg::BITS_PER_MAP_BLOCK_DEF,
    parameter int WORD_WIDTH         = zba_pkg::WORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [zba_pkg::FDZ_W-1:0] i_cfg_wdata,
    // command channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [zba_pkg::CMD_W-1:0] i_command,
    input  logic [zba_pkg::BLK_W-1:0] i_block_number,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [zba_pkg::ST_W-1:0]  o_status,
    output logic [zba_pkg::BLK_W-1:0] o_allocated_block,
    output logic [zba_pkg::MB_W-1:0]  o_changed_map_block,
    output logic                      o_changed
);
    import zba_pkg::*;

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    localparam int WW         = WORD_WIDTH;
    localparam int BW         = $clog2(WW);
    localparam int TOTAL_BITS = MAP_BLOCKS * BITS_PER_MAP_BLOCK;
    localparam int WORD_COUNT = (TOTAL_BITS + WW - 1) / WW;
    localparam int SUM_WORDS  = (WORD_COUNT + WW - 1) / WW;
    localparam int PW         = $clog2(TOTAL_BITS);
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SAW        = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int SCW        = $clog2(SUM_WORDS + 1);

    // Division by WW through a reciprocal multiply, exact for x < 2**N with
    // shift N+BW and multiplier ceil(2**shift / WW).
    localparam int    S1  = PW + BW;
    localparam longint M1 = ((64'd1 << S1) + WW - 1) / WW;
    localparam int    P1W = 2 * PW + BW + 2;
    localparam int    S2  = AW + BW;
    localparam longint M2 = ((64'd1 << S2) + WW - 1) / WW;
    localparam int    P2W = 2 * AW + BW + 2;

    // Padding bits beyond the map are preset so they never look free.
    function automatic logic [WW-1:0] pad_mask(input int base_idx, input int limit);
        logic [WW-1:0] m;
        m = '0;
        for (int b = 0; b < WW; b++) begin
            if (base_idx + b >= limit) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [WW-1:0] DPAD = pad_mask((WORD_COUNT - 1) * WW, TOTAL_BITS);
    localparam logic [WW-1:0] SPAD = pad_mask((SUM_WORDS - 1) * WW, WORD_COUNT);

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [3:0] S_INIT = 4'd0;  // clearing pass
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;  // summary scan, one word per cycle
    localparam logic [3:0] S_AW   = 4'd3;  // issue bitmap word read
    localparam logic [3:0] S_AMOD = 4'd4;  // set bit, write back
    localparam logic [3:0] S_FQ1  = 4'd5;  // word index = p / WW
    localparam logic [3:0] S_FQ2  = 4'd6;  // bit in word, summary index
    localparam logic [3:0] S_FQ3  = 4'd7;  // summary bit, issue both reads
    localparam logic [3:0] S_FMOD = 4'd8;  // clear bit, write back
    localparam logic [3:0] S_DONE = 4'd9;  // hand result to output register

    logic [3:0]       r_state, n_state;
    logic [FDZ_W-1:0] r_fdz;
    logic [AW-1:0]    r_cnt;
    logic [SCW-1:0]   r_scan;
    logic [SAW-1:0]   r_scan_q;
    logic             r_pend;
    logic [SAW-1:0]   r_sidx;
    logic [BW-1:0]    r_sbit;
    logic [WW-1:0]    r_sum;
    logic [AW-1:0]    r_widx;
    logic [BW-1:0]    r_bit;
    logic [PW-1:0]    r_p;
    logic [ST_W-1:0]  r_res_status;
    logic             r_res_chg;

    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [BLK_W-1:0] r_out_blk;
    logic [MB_W-1:0]  r_out_mb;
    logic             r_out_chg;

    // Memory ports
    logic          dat_we, sum_we;
    logic [AW-1:0] dat_waddr, dat_raddr;
    logic [SAW-1:0] sum_waddr, sum_raddr;
    logic [WW-1:0] dat_wdata, sum_wdata, dat_rdata, sum_rdata;

    zba_ram #(.DEPTH(WORD_COUNT), .WIDTH(WW), .ADDR_W(AW)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (dat_we),
        .i_waddr(dat_waddr),
        .i_wdata(dat_wdata),
        .i_raddr(dat_raddr),
        .o_rdata(dat_rdata)
    );

    // Summary: bit w set when bitmap word w is full.
    zba_ram #(.DEPTH(SUM_WORDS), .WIDTH(WW), .ADDR_W(SAW)) u_summary (
        .i_clk  (i_clk),
        .i_we   (sum_we),
        .i_waddr(sum_waddr),
        .i_wdata(sum_wdata),
        .i_raddr(sum_raddr),
        .o_rdata(sum_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [FDZ_W-1:0] base;
    logic [BLK_W-1:0] fr_diff;
    logic             fr_range;
    logic [6:0]       sum_ffz, dat_ffz;
    logic [BW-1:0]    dat_bit;
    logic [WW-1:0]    dat_set;
    logic [AW-1:0]    a_widx;
    logic [P1W-1:0]   prod1;
    logic [P2W-1:0]   prod2;
    logic [4:0]       mb_cnt;
    logic             out_load;

    // A zero first data zone behaves as one.
    assign base = ((r_fdz == '0) ? FDZ_W'(1) : r_fdz) - FDZ_W'(1);

    assign fr_diff  = i_block_number - BLK_W'(base);
    assign fr_range = (i_block_number < BLK_W'(base)) ||
                      (32'(fr_diff) >= 32'(TOTAL_BITS));

    // Upper bits past WW read as ones so the search never picks them.
    assign sum_ffz = ffz64(~64'(~sum_rdata));
    assign dat_ffz = ffz64(~64'(~dat_rdata));
    assign dat_bit = dat_ffz[BW-1:0];
    assign dat_set = dat_rdata | (WW'(1) << dat_bit);

    assign a_widx = AW'(32'(r_sidx) * WW + 32'(r_sbit));

    assign prod1 = P1W'(r_p) * P1W'(M1);
    assign prod2 = P2W'(r_widx) * P2W'(M2);

    // Map block of bit position p, by compare against each block start.
    always_comb begin
        mb_cnt = '0;
        for (int k = 1; k < MAP_BLOCKS; k++) begin
            if (32'(r_p) >= 32'(k * BITS_PER_MAP_BLOCK)) begin
                mb_cnt = mb_cnt + 5'd1;
            end
        end
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Memory port steering
    // ------------------------------------------------------------------
    always_comb begin
        dat_we    = 1'b0;
        dat_waddr = r_widx;
        dat_wdata = dat_set;
        dat_raddr = r_widx;
        sum_we    = 1'b0;
        sum_waddr = r_sidx;
        sum_wdata = r_sum | (WW'(1) << r_sbit);
        sum_raddr = r_scan[SAW-1:0];
        case (r_state)
            S_INIT: begin
                dat_we    = 1'b1;
                dat_waddr = r_cnt;
                dat_wdata = ((r_cnt == '0) ? WW'(1) : '0) |
                            ((r_cnt == AW'(WORD_COUNT - 1)) ? DPAD : '0);
                sum_we    = 32'(r_cnt) < SUM_WORDS;
                sum_waddr = r_cnt[SAW-1:0];
                sum_wdata = (32'(r_cnt) == SUM_WORDS - 1) ? SPAD : '0;
            end
            S_AW: begin
                dat_raddr = a_widx;
            end
            S_AMOD: begin
                dat_we = 1'b1;
                sum_we = &dat_set;   // word just became full
            end
            S_FQ3: begin
                sum_raddr = r_sidx;
            end
            S_FMOD: begin
                dat_we    = dat_rdata[r_bit];
                dat_wdata = dat_rdata & ~(WW'(1) << r_bit);
                sum_we    = dat_rdata[r_bit] && (&dat_rdata);  // full word loses a bit
                sum_wdata = sum_rdata & ~(WW'(1) << r_sbit);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_cnt == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (fr_range) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FQ1;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && (sum_ffz < 7'(WW))) begin
                    n_state = S_AW;
                end else if (r_pend && (r_scan_q == SAW'(SUM_WORDS - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_AW:   n_state = S_AMOD;
            S_AMOD: n_state = S_DONE;
            S_FQ1:  n_state = S_FQ2;
            S_FQ2:  n_state = S_FQ3;
            S_FQ3:  n_state = S_FMOD;
            S_FMOD: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_fdz   <= FDZ_W'(1);
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fdz <= i_cfg_wdata;
            end
            if (r_state == S_INIT) begin
                r_cnt <= r_cnt + AW'(1);
            end
            r_pend <= (r_state == S_SCAN);
        end
    end

    // Working registers; no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_scan       <= '0;
                r_p          <= PW'(fr_diff);
                r_res_chg    <= 1'b0;
                // block number only matters for a free
                r_res_status <= ((i_command == CMD_FREE) && fr_range) ? ST_RANGE : ST_FULL;
            end
            S_SCAN: begin
                r_scan   <= r_scan + SCW'(1);
                r_scan_q <= r_scan[SAW-1:0];
                r_sidx   <= r_scan_q;
                r_sbit   <= sum_ffz[BW-1:0];
                r_sum    <= sum_rdata;
            end
            S_AW: begin
                r_widx <= a_widx;
            end
            S_AMOD: begin
                r_p          <= PW'(32'(r_widx) * WW + 32'(dat_bit));
                r_res_status <= ST_ALLOC;
                r_res_chg    <= 1'b1;
            end
            S_FQ1: begin
                r_widx <= prod1[S1 +: AW];
            end
            S_FQ2: begin
                r_bit  <= BW'(32'(r_p) - 32'(r_widx) * WW);
                r_sidx <= prod2[S2 +: SAW];
            end
            S_FQ3: begin
                r_sbit <= BW'(32'(r_widx) - 32'(r_sidx) * WW);
            end
            S_FMOD: begin
                r_res_status <= dat_rdata[r_bit] ? ST_FREED : ST_CLEAR;
                r_res_chg    <= dat_rdata[r_bit];
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_chg    <= r_res_chg;
            r_out_mb     <= r_res_chg ? mb_cnt[MB_W-1:0] : '0;
            r_out_blk    <= (r_res_status == ST_ALLOC) ?
                            BLK_W'(32'(base) + 32'(r_p)) : '0;
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_allocated_block   = r_out_blk;
    assign o_changed_map_block = r_out_mb;
    assign o_changed           = r_out_chg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Summary said the word had a free bit, so the word read back must have one.
    a_summary_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_AMOD |-> !(&dat_rdata))
        else $error("bitmap word full although summary marked it free");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state != S_IDLE)
        else $error("transfer accepted without starting work");

    a_alloc_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ALLOC |-> o_changed)
        else $error("allocation reported without a changed map block");

    a_nochange_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_changed |-> o_changed_map_block == '0 && o_allocated_block == '0)
        else $error("unchanged result carries nonzero block fields");

endmodule

// ===== sim/zone_bitmap_allocator_tb.sv =====
// Self-checking testbench for zone_bitmap_allocator: a predictor of the usage bitmap is
// checked against every result transfer. Depends on zba_pkg and the allocator RTL only.
module zone_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zba_pkg::*;

    // Map geometry at the default parameters of the block.
    localparam int unsigned MAP_BLOCK_SPAN = BITS_PER_MAP_BLOCK_DEF;
    localparam int unsigned WORD_BITS      = WORD_WIDTH_DEF;
    localparam int unsigned MAP_BITS       = MAP_BLOCKS_DEF * BITS_PER_MAP_BLOCK_DEF;
    localparam int unsigned MAP_WORDS      = MAP_BITS / WORD_BITS;

    // The settle time after the last result covers the slowest allocate. The limit
    // is several times the slowest legal run, with every command at worst latency
    // under the heaviest stalls and the clearing pass after reset.
    localparam int unsigned SETTLE_CYCLES   = 100;
    localparam int unsigned RX_HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned PHASE_ITEMS     = 362;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [BLK_W-1:0] block_number;
    } t_zone_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BLK_W-1:0] allocated_block;
        logic [MB_W-1:0]  changed_map_block;
        logic             changed;
    } t_zone_result;

    // DUT ports; every input has a known value from time zero.
    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [FDZ_W-1:0] i_cfg_wdata    = '0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_ready;
    logic [CMD_W-1:0] i_command      = CMD_ALLOC;
    logic [BLK_W-1:0] i_block_number = '0;
    logic             o_out_valid;
    logic             i_out_ready    = 1'b0;
    logic [ST_W-1:0]  o_status;
    logic [BLK_W-1:0] o_allocated_block;
    logic [MB_W-1:0]  o_changed_map_block;
    logic             o_changed;

    // Shadow of the block: usage bitmap words plus the first data zone register.
    // first_open_word: every word below it is known to be full, so scans start there.
    logic [WORD_BITS-1:0] usage_words [MAP_WORDS];
    logic [FDZ_W-1:0]     zone_cfg;
    int unsigned          first_open_word;

    t_zone_cmd    pending_cmds [$];      // commands waiting for the driver
    t_zone_result expected_results [$];  // predicted results, oldest first
    t_zone_cmd    next_cmd;
    t_zone_result want;

    int unsigned items_queued    = 0;
    int unsigned items_accepted  = 0;
    int unsigned allocs_queued   = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned status_seen [0:7];

    // Idle mix, set per phase by the stimulus process.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    // Long receiver hold-off, counted in its own process.
    logic        rx_hold_arm  = 1'b0;
    int unsigned rx_hold_left = 0;

    zone_bitmap_allocator u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_block_number      (i_block_number),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_allocated_block   (o_allocated_block),
        .o_changed_map_block (o_changed_map_block),
        .o_changed           (o_changed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Map origin: a register value of zero behaves as one.
    function automatic int unsigned zone_base();
        int unsigned z;
        z = zone_cfg;
        if (z != 0) begin
            z = z - 1;
        end
        return z;
    endfunction

    // Apply one command to the shadow bitmap and return the result it must produce.
    function automatic t_zone_result predict_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [BLK_W-1:0] number);
        t_zone_result res;
        int unsigned  base;
        int unsigned  pos;
        int unsigned  w;
        int unsigned  b;
        res  = '0;
        base = zone_base();
        if (cmd == CMD_ALLOC) begin
            // First fit: lowest word with a clear bit, then lowest clear bit in it.
            w = first_open_word;
            while (w < MAP_WORDS && usage_words[w] == '1) begin
                w++;
            end
            first_open_word = w;
            if (w == MAP_WORDS) begin
                res.status = ST_FULL;
            end else begin
                b = 0;
                while (usage_words[w][b]) begin
                    b++;
                end
                usage_words[w][b]     = 1'b1;
                pos                   = w * WORD_BITS + b;
                res.status            = ST_ALLOC;
                res.allocated_block   = BLK_W'(base + pos);
                res.changed_map_block = MB_W'(pos / MAP_BLOCK_SPAN);
                res.changed           = 1'b1;
            end
        end else if (number < base || number - base >= MAP_BITS) begin
            res.status = ST_RANGE;
        end else begin
            pos = number - base;
            if (usage_words[pos / WORD_BITS][pos % WORD_BITS]) begin
                usage_words[pos / WORD_BITS][pos % WORD_BITS] = 1'b0;
                if (pos / WORD_BITS < first_open_word) begin
                    first_open_word = pos / WORD_BITS;
                end
                res.status            = ST_FREED;
                res.changed_map_block = MB_W'(pos / MAP_BLOCK_SPAN);
                res.changed           = 1'b1;
            end else begin
                res.status = ST_CLEAR;
            end
        end
        return res;
    endfunction

    function automatic void queue_cmd(input logic [CMD_W-1:0] cmd,
                                      input logic [BLK_W-1:0] number);
        t_zone_cmd c;
        c.command      = cmd;
        c.block_number = number;
        pending_cmds.push_back(c);
        items_queued++;
    endfunction

    // Mostly meaningful traffic: allocates, and frees aimed at the low region where
    // first fit keeps the live blocks. The rest hits the map edges or is pure noise.
    function automatic void queue_random_cmd();
        int unsigned base;
        int unsigned pick;
        base = zone_base();
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            queue_cmd(CMD_ALLOC, BLK_W'($urandom));
            allocs_queued++;
        end else if (pick < 85) begin
            queue_cmd(CMD_FREE, BLK_W'(base + $urandom_range(0, allocs_queued / 2 + 64)));
        end else if (pick < 93) begin
            case ($urandom_range(0, 3))
                0:       queue_cmd(CMD_FREE, BLK_W'(base - 1));
                1:       queue_cmd(CMD_FREE, BLK_W'(base));
                2:       queue_cmd(CMD_FREE, BLK_W'(base + MAP_BITS - 1));
                default: queue_cmd(CMD_FREE, BLK_W'(base + MAP_BITS));
            endcase
        end else begin
            queue_cmd(CMD_FREE, BLK_W'($urandom));
        end
    endfunction

    // Sender pause: nothing left to send and every predicted result checked.
    task automatic wait_all_results();
        while (items_accepted != items_queued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Only called while the block is idle; the shadow register follows the write.
    task automatic write_zone_cfg(input logic [FDZ_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        zone_cfg     = value;
    endtask

    // Command driver: predicts at each transfer, then offers the next pending item.
    // Valid is only dropped or reloaded once the current item has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_command(i_command, i_block_number));
                items_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_cmd        = pending_cmds.pop_front();
                    i_in_valid     <= 1'b1;
                    i_command      <= next_cmd.command;
                    i_block_number <= next_cmd.block_number;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_arm) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Result monitor: every transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            status_seen[o_status]++;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing outstanding: status %0d", o_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_allocated_block !== want.allocated_block) begin
                    $error("allocated_block: expected %0d, actual %0d",
                           want.allocated_block, o_allocated_block);
                    mismatch_count++;
                end
                if (o_changed_map_block !== want.changed_map_block) begin
                    $error("changed_map_block: expected %0d, actual %0d",
                           want.changed_map_block, o_changed_map_block);
                    mismatch_count++;
                end
                if (o_changed !== want.changed) begin
                    $error("changed: expected %0d, actual %0d", want.changed, o_changed);
                    mismatch_count++;
                end
            end
        end
        if (rx_hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned base;
        foreach (usage_words[i]) begin
            usage_words[i] = '0;
        end
        usage_words[0][0] = 1'b1;   // reserved position
        zone_cfg          = 16'd1;
        first_open_word   = 0;
        foreach (status_seen[i]) begin
            status_seen[i] = 0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, register at its reset value: first allocations, freeing the
        // reserved position, freeing a clear bit, top of the map and out of range.
        queue_cmd(CMD_ALLOC, '0);
        queue_cmd(CMD_ALLOC, '1);
        queue_cmd(CMD_FREE, 17'd0);
        queue_cmd(CMD_ALLOC, '0);
        queue_cmd(CMD_FREE, 17'd2);
        queue_cmd(CMD_FREE, 17'd2);
        queue_cmd(CMD_FREE, 17'd65535);
        queue_cmd(CMD_FREE, 17'd65536);
        queue_cmd(CMD_FREE, 17'd131071);
        wait_all_results();

        // Zero first data zone maps like one.
        write_zone_cfg(16'd0);
        queue_cmd(CMD_FREE, 17'd0);
        queue_cmd(CMD_ALLOC, '0);
        queue_cmd(CMD_FREE, 17'd65536);
        wait_all_results();

        // Highest first data zone: both edges of the map at the top of the number range.
        write_zone_cfg(16'hFFFF);
        queue_cmd(CMD_FREE, 17'd65533);
        queue_cmd(CMD_FREE, 17'd0);
        queue_cmd(CMD_FREE, 17'd65534);
        queue_cmd(CMD_FREE, 17'd65535);
        queue_cmd(CMD_ALLOC, '0);
        queue_cmd(CMD_FREE, 17'd131069);
        queue_cmd(CMD_FREE, 17'd131070);
        queue_cmd(CMD_FREE, 17'd131071);
        queue_cmd(CMD_ALLOC, '1);
        wait_all_results();

        // Random phases, one idle mix each. Halfway through each phase the sender
        // waits for every outstanding result; in the first phase the receiver also
        // holds off long enough for the block to back up into the command channel.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_zone_cfg(FDZ_W'($urandom_range(2, 65534)));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    write_zone_cfg(16'hFFFF);
                    tx_idle_pct  = 86;
                    rx_stall_pct = 0;
                end
                2: begin
                    write_zone_cfg(16'd0);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 86;
                end
                default: begin
                    write_zone_cfg(FDZ_W'($urandom_range(2, 65534)));
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
            endcase
            repeat (PHASE_ITEMS / 2) queue_random_cmd();
            if (ph == 0) begin
                @(posedge i_clk);
                rx_hold_arm <= 1'b1;
                @(posedge i_clk);
                rx_hold_arm <= 1'b0;
            end
            wait_all_results();
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) queue_random_cmd();
            wait_all_results();
        end

        // Back at first data zone one, back to back: free a middle and the top
        // position of the map, then take a few more blocks.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_zone_cfg(16'd1);
        base = zone_base();
        queue_cmd(CMD_FREE, BLK_W'(base + 40000));
        queue_cmd(CMD_FREE, BLK_W'(base + MAP_BITS - 1));
        repeat (3) queue_cmd(CMD_ALLOC, BLK_W'($urandom));
        wait_all_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: directed edges, four idle/stall mixes, first data zone",
                 items_accepted);
        $display("0, 1, 65535 and random; %0d alloc %0d full %0d freed %0d clear %0d range",
                 status_seen[ST_ALLOC], status_seen[ST_FULL], status_seen[ST_FREED],
                 status_seen[ST_CLEAR], status_seen[ST_RANGE]);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
